[rtl/msus_pkg.sv]
// ----------------------------------------------------------------------------
// msus_pkg
// Shared types and constants for the mark-smallest-unmarked-sum block.
// ----------------------------------------------------------------------------
package msus_pkg;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam int unsigned SUM_W = 30;
  localparam logic [SUM_W-1:0] SUM_MAX = 30'h3FFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic        start_set;
    logic [19:0] value;
    logic [9:0]  entry_index;
    logic [10:0] mark_count;
  } in_word_t;

  typedef struct packed {
    logic [29:0] remaining_sum;
    logic        bad_index;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT_I,
    ST_SORT_CUR,
    ST_SORT_J,
    ST_SORT_OJ,
    ST_SORT_VJ,
    ST_Q_IDX,
    ST_Q_IDXW,
    ST_Q_SCAN,
    ST_Q_ORD,
    ST_Q_CHK,
    ST_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_QSTART,
    OP_SORT_RDI,
    OP_SORT_CUR,
    OP_SORT_RDJ,
    OP_SORT_OJ,
    OP_SORT_SHIFT,
    OP_SORT_PLACE,
    OP_SORT_FIN,
    OP_IDX_RD,
    OP_IDX_BAD,
    OP_IDX_WR,
    OP_SCAN_RD,
    OP_ORD,
    OP_CHK,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic order_ready;
    logic i_end;
    logic j_zero;
    logic gt;
    logic idx_ok;
    logic scan_end;
    logic out_full;
  } stat_t;

endpackage

[rtl/msus_ram.sv]
// ----------------------------------------------------------------------------
// msus_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msus_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/msus_ctrl.sv]
// ----------------------------------------------------------------------------
// msus_ctrl
// Sequencer: load/query dispatch, order rebuild, index mark and scan.
// ----------------------------------------------------------------------------
module msus_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_kind,
  input  logic           out_ready,
  input  msus_pkg::stat_t st,
  output logic           in_ready,
  output msus_pkg::cmd_t cmd
);
  import msus_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_kind == KIND_QUERY) begin
          state_nxt = st.order_ready ? ST_Q_IDX : ST_SORT_I;
        end
      end
      ST_SORT_I:   state_nxt = st.i_end ? ST_Q_IDX : ST_SORT_CUR;
      ST_SORT_CUR: state_nxt = ST_SORT_J;
      ST_SORT_J:   state_nxt = st.j_zero ? ST_SORT_I : ST_SORT_OJ;
      ST_SORT_OJ:  state_nxt = ST_SORT_VJ;
      ST_SORT_VJ:  state_nxt = st.gt ? ST_SORT_J : ST_SORT_I;
      ST_Q_IDX:    state_nxt = st.idx_ok ? ST_Q_IDXW : ST_Q_SCAN;
      ST_Q_IDXW:   state_nxt = ST_Q_SCAN;
      ST_Q_SCAN:   state_nxt = st.scan_end ? ST_DONE : ST_Q_ORD;
      ST_Q_ORD:    state_nxt = ST_Q_CHK;
      ST_Q_CHK:    state_nxt = ST_Q_SCAN;
      ST_DONE: begin
        if (!st.out_full || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    cmd.op   = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op = (in_kind == KIND_QUERY) ? OP_QSTART : OP_LOAD;
        end
      end
      ST_SORT_I:   cmd.op = st.i_end ? OP_SORT_FIN : OP_SORT_RDI;
      ST_SORT_CUR: cmd.op = OP_SORT_CUR;
      ST_SORT_J:   cmd.op = st.j_zero ? OP_SORT_PLACE : OP_SORT_RDJ;
      ST_SORT_OJ:  cmd.op = OP_SORT_OJ;
      ST_SORT_VJ:  cmd.op = st.gt ? OP_SORT_SHIFT : OP_SORT_PLACE;
      ST_Q_IDX:    cmd.op = st.idx_ok ? OP_IDX_RD : OP_IDX_BAD;
      ST_Q_IDXW:   cmd.op = OP_IDX_WR;
      ST_Q_SCAN:   cmd.op = st.scan_end ? OP_NONE : OP_SCAN_RD;
      ST_Q_ORD:    cmd.op = OP_ORD;
      ST_Q_CHK:    cmd.op = OP_CHK;
      ST_DONE: begin
        if (!st.out_full || out_ready) begin
          cmd.op = OP_OUT;
        end
      end
      default:     cmd.op = OP_NONE;
    endcase
  end

endmodule

[rtl/msus_dp.sv]
// ----------------------------------------------------------------------------
// msus_dp
// Datapath: value, mark and order RAMs, counters, running sum, result word.
// ----------------------------------------------------------------------------
module msus_dp #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  msus_pkg::in_word_t  in_data,
  input  logic                out_ready,
  input  msus_pkg::cmd_t      cmd,
  output msus_pkg::stat_t     st,
  output logic                out_valid,
  output msus_pkg::out_word_t out_data
);
  import msus_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned TW = VALUE_WIDTH + CW;
  localparam int unsigned XW = (TW > SUM_W) ? TW : SUM_W;

  logic [CW-1:0]          cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt, pos_r, pos_nxt;
  logic [TW-1:0]          total_r, total_nxt;
  logic [VALUE_WIDTH-1:0] cur_r, cur_nxt;
  logic [AW-1:0]          oj_r, oj_nxt;
  logic [9:0]             idx_r, idx_nxt;
  logic [10:0]            mcnt_r, mcnt_nxt;
  logic                   ord_ok_r, ord_ok_nxt, bad_r, bad_nxt, ovld_r, ovld_nxt;
  out_word_t              odata_r, odata_nxt;

  logic                   v_we, m_we, o_we, m_wdata, m_rdata;
  logic [AW-1:0]          v_waddr, v_raddr, m_waddr, m_raddr, o_waddr, o_raddr;
  logic [AW-1:0]          o_wdata, o_rdata;
  logic [VALUE_WIDTH-1:0] v_wdata, v_rdata;
  logic [CW-1:0]          cnt_eff;
  logic [TW-1:0]          total_eff;
  logic [AW-1:0]          idx_addr;

  msus_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata)
  );
  msus_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_mark (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rdata)
  );
  msus_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_ord (
    .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
    .raddr(o_raddr), .rdata(o_rdata)
  );

  assign cnt_eff   = in_data.start_set ? '0 : cnt_r;
  assign total_eff = in_data.start_set ? '0 : total_r;
  assign idx_addr  = AW'(idx_r);

  always_comb begin
    st.order_ready = ord_ok_r;
    st.i_end       = (i_r == cnt_r);
    st.j_zero      = (j_r == '0);
    st.gt          = (v_rdata > cur_r);
    st.idx_ok      = (32'(idx_r) < 32'(cnt_r));
    st.scan_end    = (mcnt_r == '0) || (pos_r >= cnt_r);
    st.out_full    = ovld_r;
  end

  // RAM ports; reads run every cycle, data is used the cycle after
  always_comb begin
    v_we    = 1'b0;
    v_waddr = cnt_eff[AW-1:0];
    v_wdata = VALUE_WIDTH'(in_data.value);
    v_raddr = o_rdata;
    m_we    = 1'b0;
    m_waddr = cnt_eff[AW-1:0];
    m_wdata = 1'b0;
    m_raddr = o_rdata;
    o_we    = 1'b0;
    o_waddr = j_r[AW-1:0];
    o_wdata = i_r[AW-1:0];
    o_raddr = pos_r[AW-1:0];
    case (cmd.op)
      OP_LOAD: begin
        v_we = (32'(cnt_eff) < DEPTH);
        m_we = v_we;
      end
      OP_SORT_RDI:   v_raddr = i_r[AW-1:0];
      OP_SORT_RDJ:   o_raddr = AW'(j_r - CW'(1));
      OP_SORT_SHIFT: begin
        o_we    = 1'b1;
        o_wdata = oj_r;
      end
      OP_SORT_PLACE: o_we = 1'b1;
      OP_IDX_RD: begin
        v_raddr = idx_addr;
        m_raddr = idx_addr;
      end
      OP_IDX_WR: begin
        m_we    = !m_rdata;
        m_waddr = idx_addr;
        m_wdata = 1'b1;
      end
      OP_CHK: begin
        m_we    = !m_rdata;
        m_waddr = oj_r;
        m_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    pos_nxt    = pos_r;
    total_nxt  = total_r;
    cur_nxt    = cur_r;
    oj_nxt     = oj_r;
    idx_nxt    = idx_r;
    mcnt_nxt   = mcnt_r;
    ord_ok_nxt = ord_ok_r;
    bad_nxt    = bad_r;
    ovld_nxt   = ovld_r && !out_ready;
    odata_nxt  = odata_r;
    case (cmd.op)
      OP_LOAD: begin
        ord_ok_nxt = 1'b0;
        if (in_data.start_set) begin
          pos_nxt = '0;
        end
        if (32'(cnt_eff) < DEPTH) begin
          cnt_nxt   = cnt_eff + CW'(1);
          total_nxt = total_eff + TW'(VALUE_WIDTH'(in_data.value));
        end else begin
          cnt_nxt   = cnt_eff;
          total_nxt = total_eff;
        end
      end
      OP_QSTART: begin
        idx_nxt  = in_data.entry_index;
        mcnt_nxt = in_data.mark_count;
        bad_nxt  = 1'b0;
        i_nxt    = '0;
      end
      OP_SORT_CUR: begin
        cur_nxt = v_rdata;
        j_nxt   = i_r;
      end
      OP_SORT_OJ:    oj_nxt = o_rdata;
      OP_SORT_SHIFT: j_nxt  = j_r - CW'(1);
      OP_SORT_PLACE: i_nxt  = i_r + CW'(1);
      OP_SORT_FIN: begin
        ord_ok_nxt = 1'b1;
        pos_nxt    = '0;
      end
      OP_IDX_BAD: bad_nxt = 1'b1;
      OP_IDX_WR: begin
        if (!m_rdata) begin
          total_nxt = total_r - TW'(v_rdata);
        end
      end
      OP_ORD: oj_nxt = o_rdata;
      OP_CHK: begin
        if (!m_rdata) begin
          total_nxt = total_r - TW'(v_rdata);
          mcnt_nxt  = mcnt_r - 11'd1;
        end
        pos_nxt = pos_r + CW'(1);
      end
      OP_OUT: begin
        ovld_nxt                = 1'b1;
        odata_nxt.bad_index     = bad_r;
        odata_nxt.remaining_sum = (XW'(total_r) > XW'(SUM_MAX)) ? SUM_MAX
                                                                : SUM_W'(total_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      pos_r    <= '0;
      total_r  <= '0;
      ord_ok_r <= 1'b0;
      ovld_r   <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      pos_r    <= pos_nxt;
      total_r  <= total_nxt;
      ord_ok_r <= ord_ok_nxt;
      ovld_r   <= ovld_nxt;
    end
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    cur_r   <= cur_nxt;
    oj_r    <= oj_nxt;
    idx_r   <= idx_nxt;
    mcnt_r  <= mcnt_nxt;
    bad_r   <= bad_nxt;
    odata_r <= odata_nxt;
  end

  assign out_valid = ovld_r;
  assign out_data  = odata_r;

endmodule

[rtl/mark_smallest_unmarked_sum.sv]
// ----------------------------------------------------------------------------
// mark_smallest_unmarked_sum
// Value store with per-entry marks; queries mark entries and return the sum
// of the values still unmarked.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/in_data) carries one word per item.
//    kind = load appends a value (start_set empties the store first; a load
//    into a full store is dropped). kind = query marks entry_index, then the
//    mark_count smallest unmarked entries, and returns one result word.
//  - Result channel (out_valid/out_ready/out_data): remaining_sum saturated
//    to 30 bits, bad_index set when entry_index is not a loaded entry.
//  - A load does not leave the idle state; the next word is taken the following cycle.
//  - The first query after any load rebuilds the sorted index list by an
//    insertion sort over the order RAM: each entry's value is read and held,
//    then compared against earlier positions, reading the order RAM and then
//    the value RAM for each compare and shifting while the stored value is
//    greater; the entry is placed at position 0 or where a compare stops.
//  - A query is taken, then marks the index (only a bad flag when the index
//    is out of range), then scans sorted positions (marked entries are
//    skipped) until mark_count entries are marked, then posts the result;
//    scan progress carries over between queries.
//  - Reset empties the store and drops any pending result; no clearing pass.
//  - The result register lets the controller take and run a query while the
//    previous result waits; if the register is still full when that query
//    ends, it waits with in_ready low until out_ready.
// ----------------------------------------------------------------------------
module mark_smallest_unmarked_sum #(
  parameter int unsigned DEPTH       = 1024,
  parameter int unsigned VALUE_WIDTH = 20
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  msus_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output msus_pkg::out_word_t out_data
);
  import msus_pkg::*;

  cmd_t  cmd;
  stat_t st;

  // sequencer
  msus_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .out_ready(out_ready),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // storage, counters and result register
  msus_dp #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_ready(out_ready),
    .cmd      (cmd),
    .st       (st),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  // a load word never holds off the next word
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.kind == KIND_LOAD) |=> in_ready)
    else $error("load did not complete in one cycle");

  // a query word occupies the sequencer
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.kind == KIND_QUERY) |=> !in_ready)
    else $error("query did not occupy sequencer");

  // a new result only follows a query
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result posted without a query");

endmodule
